// File: hw/rtl/ntew_pkg.sv
// Shared types, token codes and helpers for the number-to-English-words block.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ntew_pkg;

   localparam int NUM_W           = 31;
   localparam int BIN_W           = NUM_W + (NUM_W % 2);  // padded to whole bit pairs
   localparam int DD_STEPS        = BIN_W / 2;            // two bits per cycle
   localparam int GROUPS          = 4;
   localparam int DIGITS          = 3 * GROUPS;
   localparam int SLOTS           = 5;                    // hund digit, Hundred, tens, ones, scale
   localparam int SLOTS_ALL       = GROUPS * SLOTS;
   localparam int WORD_W          = 5;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [WORD_W-1:0] TOK_ZERO      = 5'd0;
   localparam logic [WORD_W-1:0] TOK_TEN       = 5'd10;
   localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
   localparam logic [WORD_W-1:0] TOK_HUNDRED   = 5'd28;
   localparam logic [WORD_W-1:0] TOK_THOUSAND  = 5'd29;

   typedef logic [DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   // One double-dabble step: add 3 to every digit of 5 or more, then shift b in.
   function automatic bcd_type dd_shift(input bcd_type bcd, input logic b);
      bcd_type          adj;
      logic [4*DIGITS:0] sh;
      adj = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (adj[i] >= 4'd5) begin
            adj[i] = adj[i] + 4'd3;
         end
      end
      sh = {adj, b};
      return sh[4*DIGITS-1:0];
   endfunction

endpackage : ntew_pkg

`default_nettype wire

// File: hw/rtl/ntew_if.sv
// Valid/ready channel interfaces for the number beats and the word-token beats.
// Depends on ntew_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ntew_req_if;
   import ntew_pkg::*;
   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface : ntew_req_if

interface ntew_rsp_if;
   import ntew_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic              last_word;

   modport source (output valid, output word, output last_word, input ready);
   modport sink   (input valid, input word, input last_word, output ready);
endinterface : ntew_rsp_if

`default_nettype wire

// File: hw/rtl/ntew_front.sv
// Front end: takes a number beat and converts it to decimal digits by double
// dabble, two bits per cycle, then pushes the digits into the queue. Uses ntew_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntew_front (
   input  wire logic                clock,
   input  wire logic                reset,
   ntew_req_if.sink                 req_ch,
   input  wire ntew_pkg::q_stat_type q_stat,
   output logic                     push,
   output ntew_pkg::bcd_type        push_data
);
   import ntew_pkg::*;

   localparam int CNT_W = $clog2(DD_STEPS);

   typedef enum logic [1:0] {F_IDLE, F_CONV, F_HOLD} state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [BIN_W-1:0] bin_ff;
   bcd_type          bcd_ff;

   bcd_type bcd_step;
   logic    last_step;
   logic    accept;

   assign bcd_step  = dd_shift(dd_shift(bcd_ff, bin_ff[BIN_W-1]), bin_ff[BIN_W-2]);
   assign last_step = (state_ff == F_CONV) && (cnt_ff == CNT_W'(DD_STEPS - 1));
   assign push      = (last_step || (state_ff == F_HOLD)) && !q_stat.full;
   assign push_data = (state_ff == F_HOLD) ? bcd_ff : bcd_step;

   // next number may come in on the same cycle the finished digits leave
   assign req_ch.ready = (state_ff == F_IDLE) || push;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  state_ff <= F_CONV;
               end
            end
            F_CONV: begin
               if (last_step) begin
                  if (!push) begin
                     state_ff <= F_HOLD;
                  end else if (!accept) begin
                     state_ff <= F_IDLE;
                  end
               end
            end
            F_HOLD: begin
               if (push) begin
                  state_ff <= accept ? F_CONV : F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
         if (accept) begin
            cnt_ff <= '0;
         end else if (state_ff == F_CONV) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end

      if (accept) begin
         bin_ff <= BIN_W'(req_ch.number);
         bcd_ff <= '0;
      end else if (state_ff == F_CONV) begin
         bin_ff <= {bin_ff[BIN_W-3:0], 2'b00};
         bcd_ff <= bcd_step;
      end
   end

endmodule : ntew_front

`default_nettype wire

// File: hw/rtl/ntew_queue.sv
// Short FIFO of converted digit sets between the front end and the token sequencer.
// Uses ntew_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module ntew_queue #(
   parameter int DEPTH = ntew_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ntew_pkg::bcd_type    push_data,
   input  wire logic                 pop,
   output ntew_pkg::bcd_type         head,
   output ntew_pkg::q_stat_type      stat
);
   import ntew_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bcd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : ntew_queue

`default_nettype wire

// File: hw/rtl/ntew_back.sv
// Token sequencer: turns the digit set at the queue head into word-token beats,
// one per cycle while the receiver is ready, through an output register. Uses ntew_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntew_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ntew_pkg::bcd_type    head,
   input  wire ntew_pkg::q_stat_type q_stat,
   output logic                      pop,
   ntew_rsp_if.source                rsp_ch
);
   import ntew_pkg::*;

   // slots in reading order: group 3 first, five slots per group
   logic [SLOTS_ALL-1:0]             slot_vld;
   logic [SLOTS_ALL-1:0][WORD_W-1:0] slot_code;
   logic                             num_nz;

   logic                  busy_ff, busy_in;
   logic [SLOTS_ALL-1:0]  pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic                  last_ff, last_in;

   logic [SLOTS_ALL-1:0]  pend_cur;
   logic [SLOTS_ALL-1:0]  low;
   logic [SLOTS_ALL-1:0]  rem;
   logic [WORD_W-1:0]     tok;
   logic                  emit;

   assign num_nz = |head;

   for (genvar g = 0; g < GROUPS; g++) begin : g_grp
      localparam int BASE = (GROUPS - 1 - g) * SLOTS;
      logic [3:0] h, t, o;
      logic       teen;

      assign h    = head[3*g+2];
      assign t    = head[3*g+1];
      assign o    = head[3*g];
      assign teen = (t == 4'd1) && (o != 4'd0);

      assign slot_vld[BASE+0]  = (h != 4'd0);
      assign slot_code[BASE+0] = {1'b0, h};
      assign slot_vld[BASE+1]  = (h != 4'd0);
      assign slot_code[BASE+1] = TOK_HUNDRED;
      assign slot_vld[BASE+2]  = (t != 4'd0);
      assign slot_code[BASE+2] = teen        ? TOK_TEN + {1'b0, o} :
                                 (t == 4'd1) ? TOK_TEN : TOK_TENS_BASE + {1'b0, t};
      assign slot_vld[BASE+3]  = (o != 4'd0) && (t != 4'd1);
      assign slot_code[BASE+3] = {1'b0, o};

      if (g == 0) begin : g_low
         // lowest group has no scale word; its slot carries Zero instead
         assign slot_vld[BASE+4]  = !num_nz;
         assign slot_code[BASE+4] = TOK_ZERO;
      end else begin : g_scale
         assign slot_vld[BASE+4]  = (h != 4'd0) || (t != 4'd0) || (o != 4'd0);
         assign slot_code[BASE+4] = TOK_THOUSAND + WORD_W'(g - 1);
      end
   end

   assign pend_cur = busy_ff ? pend_ff : slot_vld;
   assign low      = pend_cur & (~pend_cur + 1'b1);
   assign rem      = pend_cur & ~low;
   assign emit     = (busy_ff || !q_stat.empty) && (!rsp_valid_ff || rsp_ch.ready);
   assign pop      = emit && (rem == '0);

   always_comb begin
      tok = '0;
      for (int k = 0; k < SLOTS_ALL; k++) begin
         if (low[k]) begin
            tok = tok | slot_code[k];
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      word_in      = word_ff;
      last_in      = last_ff;
      if (emit) begin
         busy_in      = (rem != '0);
         pend_in      = rem;
         rsp_valid_in = 1'b1;
         word_in      = tok;
         last_in      = (rem == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.word      = word_ff;
   assign rsp_ch.last_word = last_ff;

endmodule : ntew_back

`default_nettype wire

// File: hw/rtl/number_to_english_word_tokens.sv
// Path: the converter shifts each number into decimal digits two bits at a time,
// pushes the digit set into the queue, and the sequencer puts each word into the output register.
// Throughput: the double-dabble converter can take the next number as it pushes the digits of the last;
// words leave at one per cycle while words are waiting and the receiver is ready.
// Reset (synchronous): converter idle, queue empty, no word beat pending.
// Top level; depends on ntew_pkg, ntew_if, ntew_front, ntew_queue, ntew_back.
`timescale 1ns / 1ps
`default_nettype none

module number_to_english_word_tokens #(
   parameter int QUEUE_DEPTH = ntew_pkg::QUEUE_DEPTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   ntew_req_if.sink   req_ch,
   ntew_rsp_if.source rsp_ch
);
   import ntew_pkg::*;

   logic       push;
   bcd_type    push_data;
   logic       pop;
   bcd_type    head;
   q_stat_type q_stat;

   ntew_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   ntew_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (q_stat)
   );

   ntew_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule : number_to_english_word_tokens

`default_nettype wire

// File: verif/tb_number_to_english_word_tokens.sv
// Self-checking bench for number_to_english_word_tokens: random and directed numbers in,
// word-token beats checked against an in-bench speller. Depends on ntew_pkg, ntew_if and the top level.
`timescale 1ns / 1ps

module tb_number_to_english_word_tokens;
   import ntew_pkg::*;

   localparam int LONG_STALL_CYCLES = 300;
   localparam int DRAIN_CYCLES      = 40;
   localparam int TEEN_LO           = 11;
   localparam int TEEN_HI           = 19;

   localparam logic [NUM_W-1:0] DIRECTED_NUMBERS [24] = '{
      31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd19, 31'd20, 31'd99,
      31'd100, 31'd110, 31'd115, 31'd1000, 31'd1010, 31'd100010, 31'd123000,
      31'd1000000, 31'd1000001, 31'd7000000, 31'd20000019, 31'd999999999,
      31'd1000000000, 31'd1234567891, 31'd2000000000, 31'h7fff_ffff
   };

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last_word;
   } word_beat_type;

   logic clock;
   logic reset;

   ntew_req_if req_bus ();
   ntew_rsp_if rsp_bus ();

   number_to_english_word_tokens dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   logic [NUM_W-1:0] pending_numbers[$];
   word_beat_type    expected_words[$];
   int               queued_count   = 0;
   int               accepted_count = 0;
   int               error_count    = 0;
   int               req_idle_pct   = 32;
   int               rsp_idle_pct   = 32;
   bit               want_long_stall = 0;
   bit               req_taken;

   always #5 clock = ~clock;

   // Spell one three-digit group into the token list.
   function automatic void spell_triplet(input int unsigned grp, ref logic [WORD_W-1:0] toks[$]);
      int unsigned hund;
      int unsigned tail;
      int unsigned tens;
      int unsigned ones;
      hund = grp / 100;
      tail = grp % 100;
      if (hund != 0) begin
         toks.push_back(WORD_W'(hund));
         toks.push_back(TOK_HUNDRED);
      end
      if (tail >= TEEN_LO && tail <= TEEN_HI) begin
         toks.push_back(WORD_W'(tail));
      end else begin
         tens = tail / 10;
         ones = tail % 10;
         if (tens == 1) begin
            toks.push_back(TOK_TEN);
         end else if (tens >= 2) begin
            toks.push_back(TOK_TENS_BASE + WORD_W'(tens));
         end
         if (ones != 0) begin
            toks.push_back(WORD_W'(ones));
         end
      end
   endfunction

   function automatic void spell_number(input logic [NUM_W-1:0] value);
      logic [WORD_W-1:0] toks[$];
      int unsigned       groups[GROUPS];
      int unsigned       rest;
      rest = 32'(value);
      if (value == 0) begin
         toks.push_back(TOK_ZERO);
      end else begin
         for (int g = 0; g < GROUPS; g++) begin
            groups[g] = rest % 1000;
            rest      = rest / 1000;
         end
         for (int g = GROUPS - 1; g >= 0; g--) begin
            if (groups[g] != 0) begin
               spell_triplet(groups[g], toks);
               // scale words follow Thousand in code order
               if (g > 0) toks.push_back(TOK_THOUSAND + WORD_W'(g - 1));
            end
         end
      end
      foreach (toks[k]) begin
         expected_words.push_back(word_beat_type'{word: toks[k],
                                                  last_word: (k == toks.size() - 1)});
      end
   endfunction

   // Mix of full-range values and numbers built from interesting groups.
   function automatic logic [NUM_W-1:0] make_number();
      longint unsigned v;
      int unsigned     g;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 999);
         2: v = $urandom_range(0, 999999);
         default: begin
            v = 0;
            for (int i = 0; i < GROUPS; i++) begin
               case ($urandom_range(0, 4))
                  0: g = 0;
                  1: g = 10;
                  2: g = $urandom_range(TEEN_LO, TEEN_HI);
                  3: g = 100 * $urandom_range(1, 9);
                  default: g = $urandom_range(0, 999);
               endcase
               if (i == 0) g = g % 3;
               v = v * 1000 + g;
            end
         end
      endcase
      return NUM_W'(v % 64'h8000_0000);
   endfunction

   // Driver: new beat only once the current one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.number <= '0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req_bus.valid  <= 1'b1;
            req_bus.number <= pending_numbers.pop_front();
         end else begin
            req_bus.valid  <= 1'b0;
            req_bus.number <= NUM_W'($urandom);
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off.
   int  stall_left      = 0;
   bit  long_stall_done = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (want_long_stall && !long_stall_done) begin
         rsp_bus.ready <= 1'b0;
         stall_left      = LONG_STALL_CYCLES;
         long_stall_done = 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Monitor: predict on each number beat, check each word beat.
   always @(posedge clock) begin
      word_beat_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            spell_number(req_bus.number);
            accepted_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word beat: expected none, actual word %0d last %0b",
                        $time, rsp_bus.word, rsp_bus.last_word);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.word !== want.word) begin
                  $display("%0t: word mismatch: expected %0d, actual %0d",
                           $time, want.word, rsp_bus.word);
                  error_count++;
               end
               if (rsp_bus.last_word !== want.last_word) begin
                  $display("%0t: last_word mismatch: expected %0b, actual %0b",
                           $time, want.last_word, rsp_bus.last_word);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic push_random(input int count);
      repeat (count) begin
         pending_numbers.push_back(make_number());
         queued_count++;
      end
   endtask

   // Returns on a rising edge so the caller can change knobs safely.
   task automatic wait_sent(input bit drain);
      do @(negedge clock);
      while (accepted_count < queued_count || (drain && expected_words.size() != 0));
      @(posedge clock);
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.number = '0;
      rsp_bus.ready  = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_NUMBERS[i]) begin
         pending_numbers.push_back(DIRECTED_NUMBERS[i]);
         queued_count++;
      end
      wait_sent(1'b1);

      // receiver holds off while numbers keep coming, so the input backs up
      want_long_stall = 1;
      push_random(24);
      wait_sent(1'b1);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      push_random(40);
      wait_sent(1'b0);

      req_idle_pct = 32;
      rsp_idle_pct = 32;
      push_random(72);
      wait_sent(1'b1);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule : tb_number_to_english_word_tokens

// File: files.f
hw/rtl/ntew_pkg.sv
hw/rtl/ntew_if.sv
hw/rtl/ntew_front.sv
hw/rtl/ntew_queue.sv
hw/rtl/ntew_back.sv
hw/rtl/number_to_english_word_tokens.sv
verif/tb_number_to_english_word_tokens.sv
